### design/arp_icmp_responder_filter_macros.svh
// Assertion macros shared by the responder RTL.
// Needs a clk and an active-low rst_n in the module that uses them.
`ifndef ARP_ICMP_RESPONDER_FILTER_MACROS_SVH
`define ARP_ICMP_RESPONDER_FILTER_MACROS_SVH

// same-cycle implication
`define AICR_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define AICR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### design/aicr_pkg.sv
// Shared types and constants of the ARP/ICMP responder.
// No dependencies.
package aicr_pkg;

  localparam logic [1:0] ACT_DROP     = 2'd0;
  localparam logic [1:0] ACT_REPLY    = 2'd1;
  localparam logic [1:0] ACT_HOST     = 2'd2;
  localparam logic [1:0] ACT_OVERSIZE = 2'd3;

  localparam logic [47:0] MAC_RESET = 48'h0080E1010203;

  localparam int HDR_SLOTS = 15;
  localparam int HDR_FIXED = 12;
  // fixed header bytes fetched after frame end; three more follow at the L4 offset
  localparam logic [6:0] HDR_ADDR [HDR_FIXED] =
    '{7'd12, 7'd13, 7'd14, 7'd16, 7'd17, 7'd18, 7'd19, 7'd23, 7'd30, 7'd31, 7'd32, 7'd33};

  typedef logic [HDR_SLOTS-1:0][7:0] hdr_t;

  typedef enum logic [1:0] {MODE_NONE, MODE_ICMP, MODE_ARP} mode_t;

  typedef struct packed {
    logic [1:0]  action;
    mode_t       mode;
    logic [16:0] olen;
    logic [8:0]  n;
    logic [6:0]  p;
  } dec_t;

endpackage

### design/arp_icmp_responder_filter.sv
// Top level of the ARP/ICMP echo responder with host filter.
// Depends on aicr_pkg, aicr_ram, aicr_decide and the assertion macro header.
//
// Input stream: tuser = cmd (0 frame byte, 1 readout tick), tdata = data byte,
// tlast = frame end. Output stream: tuser = result kind, tlast = last byte,
// tdata = action, frame length and byte. Registers on an APB port, 64-bit data.
// Frame bytes are stored at one per cycle. After the last byte the block
// fetches 15 header bytes from the store, decides, and for a reply edits the
// frame in place through the store's ports: MAC copy of 6 bytes, 6 MAC writes,
// body copy of n bytes (n = 4 for ICMP, hln+pln for ARP), 11 or 12 body
// writes, then the verdict transfer. A readout tick's byte passes the store's
// registered read and the single output register. Input is held off from
// frame end until the verdict is sent and after a readout tick. Reset clears
// control state and the IP and port registers and sets MAC to MAC_RESET; the
// frame store is not cleared, so it is usable right after reset. A stalled
// receiver holds the result in the output register and stops the input side.
module arp_icmp_responder_filter #(
  parameter int FRAME_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] action, [13:2] frame_length, [21:14] out_byte
  output logic        out_tuser,  // [0] result_kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "arp_icmp_responder_filter_macros.svh"

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int WCW = $clog2(FRAME_BYTES + 2);
  localparam logic [WCW-1:0] FB_LIM  = WCW'(FRAME_BYTES);
  localparam logic [WCW-1:0] FB_OVER = WCW'(FRAME_BYTES + 1);

  localparam logic [1:0] REG_IP   = 2'd0;
  localparam logic [1:0] REG_MAC  = 2'd1;
  localparam logic [1:0] REG_PORT = 2'd2;

  typedef enum logic [2:0] {ST_IDLE, ST_GATH, ST_DEC, ST_COPY, ST_WLIST, ST_VERD} state_t;
  typedef enum logic [1:0] {PH_MACCP, PH_MACWR, PH_BODYCP, PH_BODYWR} phase_t;

  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [WCW-1:0] wc_r, wc_nxt, len_r, len_nxt, ri_r, ri_nxt, olen_r, olen_nxt;
  logic [1:0] verd_r, verd_nxt;
  aicr_pkg::mode_t mode_r, mode_nxt;
  logic [8:0] n_r, n_nxt;
  logic [6:0] p_r, p_nxt;
  aicr_pkg::hdr_t hdr_r, hdr_nxt;
  logic [3:0] gi_r, gi_nxt, gidx_r, gidx_nxt;
  logic gv_r, gv_nxt;
  logic [AW-1:0] cp_src_r, cp_src_nxt, cp_dst_r, cp_dst_nxt, wa_r, wa_nxt;
  logic [8:0] cp_cnt_r, cp_cnt_nxt, cp_i_r, cp_i_nxt;
  logic wv_r, wv_nxt;
  logic wl_mac_r, wl_mac_nxt;
  logic [3:0] wl_j_r, wl_j_nxt;
  logic pend_r, pend_nxt, phit_r, phit_nxt, plast_r, plast_nxt;
  logic out_valid_r, out_valid_nxt, out_kind_r, out_kind_nxt;
  logic [1:0] out_act_r, out_act_nxt;
  logic [11:0] out_len_r, out_len_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic out_last_r, out_last_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [15:0] port_r, port_nxt;

  logic in_acc, out_free, adv;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;
  aicr_pkg::dec_t dec;
  logic [6:0] pg;
  logic [3:0] wl_len;
  logic [AW-1:0] wl_addr;
  logic [7:0] wl_data;
  logic [7:0] mb [6];
  logic [7:0] ib [4];

  aicr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  aicr_decide #(.LEN_W(WCW)) u_decide (
    .hdr(hdr_r), .len(len_r), .local_ip(ip_r), .control_port(port_r), .dec(dec)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (st_r == ST_IDLE) && !pend_r && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_byte_r, out_len_r, out_act_r};
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[4:3])
      REG_IP:   cfg_prdata = {32'd0, ip_r};
      REG_MAC:  cfg_prdata = {16'd0, mac_r};
      REG_PORT: cfg_prdata = {48'd0, port_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // edit write lists
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mb[k] = mac_r[47-8*k -: 8];
    end
    for (int k = 0; k < 4; k++) begin
      ib[k] = ip_r[31-8*k -: 8];
    end
    wl_addr = '0;
    wl_data = '0;
    if (wl_mac_r) begin
      wl_len  = 4'd6;
      wl_addr = AW'(6) + AW'(wl_j_r);
      wl_data = mb[3'(wl_j_r)];
    end else if (mode_r == aicr_pkg::MODE_ICMP) begin
      wl_len = 4'd11;
      if (wl_j_r == 4'd0) begin
        wl_addr = AW'(22);
        wl_data = 8'd64;
      end else if (wl_j_r < 4'd3) begin
        wl_addr = AW'(23) + AW'(wl_j_r);
      end else if (wl_j_r < 4'd7) begin
        wl_addr = AW'(23) + AW'(wl_j_r);
        wl_data = hdr_r[4'd5 + wl_j_r];
      end else begin
        wl_addr = AW'(p_r) + AW'(wl_j_r - 4'd7);
      end
    end else begin
      wl_len = 4'd12;
      if (wl_j_r == 4'd0) begin
        wl_addr = AW'(20);
      end else if (wl_j_r == 4'd1) begin
        wl_addr = AW'(21);
        wl_data = 8'd2;
      end else if (wl_j_r < 4'd8) begin
        wl_addr = AW'(20) + AW'(wl_j_r);
        wl_data = mb[3'(wl_j_r - 4'd2)];
      end else begin
        wl_addr = AW'(20) + AW'(wl_j_r);
        wl_data = ib[2'(wl_j_r - 4'd8)];
      end
    end
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; wc_nxt = wc_r; len_nxt = len_r; ri_nxt = ri_r;
    olen_nxt = olen_r; verd_nxt = verd_r; mode_nxt = mode_r; n_nxt = n_r; p_nxt = p_r;
    hdr_nxt = hdr_r; gi_nxt = gi_r; gidx_nxt = gidx_r; gv_nxt = 1'b0;
    cp_src_nxt = cp_src_r; cp_dst_nxt = cp_dst_r; cp_cnt_nxt = cp_cnt_r; cp_i_nxt = cp_i_r;
    wa_nxt = wa_r; wv_nxt = 1'b0; wl_mac_nxt = wl_mac_r; wl_j_nxt = wl_j_r;
    pend_nxt = 1'b0; phit_nxt = phit_r; plast_nxt = plast_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt = out_kind_r; out_act_nxt = out_act_r; out_len_nxt = out_len_r;
    out_byte_nxt = out_byte_r; out_last_nxt = out_last_r;
    ip_nxt = ip_r; mac_nxt = mac_r; port_nxt = port_r;
    ram_we = 1'b0; ram_waddr = wa_r; ram_wdata = ram_rdata; ram_raddr = '0;
    adv = 1'b0;
    pg = 7'd14 + 7'({hdr_r[2][3:0], 2'b00});

    if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:3])
        REG_IP:   ip_nxt = cfg_pwdata[31:0];
        REG_MAC:  mac_nxt = cfg_pwdata[47:0];
        REG_PORT: port_nxt = cfg_pwdata[15:0];
        default:  ;
      endcase
    end

    if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = 1'b1;
      out_act_nxt   = '0;
      out_len_nxt   = '0;
      out_byte_nxt  = phit_r ? ram_rdata : 8'd0;
      out_last_nxt  = phit_r ? plast_r : 1'b1;
    end

    if (wv_r) begin
      ram_we = 1'b1;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc && in_tuser) begin
          pend_nxt = 1'b1;
          phit_nxt = 1'b0;
          if ((verd_r == aicr_pkg::ACT_REPLY || verd_r == aicr_pkg::ACT_HOST) &&
              ri_r < olen_r) begin
            phit_nxt  = 1'b1;
            ram_raddr = AW'(ri_r);
            ri_nxt    = ri_r + 1'b1;
            plast_nxt = ({1'b0, ri_r} + 1'b1) >= {1'b0, olen_r};
          end
        end else if (in_acc) begin
          if (wc_r == '0) begin
            verd_nxt = aicr_pkg::ACT_DROP;
            olen_nxt = '0;
            ri_nxt   = '0;
          end
          if (wc_r < FB_LIM) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(wc_r);
            ram_wdata = in_tdata;
            wc_nxt    = wc_r + 1'b1;
          end else begin
            wc_nxt = FB_OVER;
          end
          if (in_tlast) begin
            len_nxt = wc_nxt;
            wc_nxt  = '0;
            ri_nxt  = '0;
            if (len_nxt > FB_LIM) begin
              verd_nxt = aicr_pkg::ACT_OVERSIZE;
              olen_nxt = '0;
              st_nxt   = ST_VERD;
            end else begin
              gi_nxt = '0;
              st_nxt = ST_GATH;
            end
          end
        end
      end
      ST_GATH: begin
        if (gv_r) begin
          hdr_nxt[gidx_r] = ram_rdata;
        end
        if (gi_r < 4'(aicr_pkg::HDR_SLOTS)) begin
          if (gi_r < 4'(aicr_pkg::HDR_FIXED)) begin
            ram_raddr = AW'(aicr_pkg::HDR_ADDR[gi_r]);
          end else if (gi_r == 4'(aicr_pkg::HDR_FIXED)) begin
            ram_raddr = AW'(pg);
          end else begin
            ram_raddr = AW'(pg) + AW'(gi_r - 4'd11);
          end
          gv_nxt   = 1'b1;
          gidx_nxt = gi_r;
          gi_nxt   = gi_r + 1'b1;
        end else if (!gv_r) begin
          st_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        verd_nxt = dec.action;
        olen_nxt = WCW'(dec.olen);
        mode_nxt = dec.mode;
        n_nxt    = dec.n;
        p_nxt    = dec.p;
        if (dec.mode == aicr_pkg::MODE_NONE) begin
          st_nxt = ST_VERD;
        end else begin
          st_nxt     = ST_COPY;
          ph_nxt     = PH_MACCP;
          cp_src_nxt = AW'(6);
          cp_dst_nxt = '0;
          cp_cnt_nxt = 9'd6;
          cp_i_nxt   = '0;
        end
      end
      ST_COPY: begin
        if (cp_i_r < cp_cnt_r) begin
          ram_raddr = cp_src_r + AW'(cp_i_r);
          wa_nxt    = cp_dst_r + AW'(cp_i_r);
          wv_nxt    = 1'b1;
          cp_i_nxt  = cp_i_r + 1'b1;
        end else if (!wv_r) begin
          adv = 1'b1;
        end
      end
      ST_WLIST: begin
        ram_we    = 1'b1;
        ram_waddr = wl_addr;
        ram_wdata = wl_data;
        wl_j_nxt  = wl_j_r + 1'b1;
        if (wl_j_r == wl_len - 1'b1) begin
          adv = 1'b1;
        end
      end
      ST_VERD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_act_nxt   = verd_r;
          out_len_nxt   = 12'(olen_r);
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b0;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (adv) begin
      case (ph_r)
        PH_MACCP: begin
          ph_nxt = PH_MACWR; st_nxt = ST_WLIST; wl_mac_nxt = 1'b1; wl_j_nxt = '0;
        end
        PH_MACWR: begin
          ph_nxt = PH_BODYCP; st_nxt = ST_COPY; cp_i_nxt = '0;
          if (mode_r == aicr_pkg::MODE_ICMP) begin
            cp_src_nxt = AW'(26); cp_dst_nxt = AW'(30); cp_cnt_nxt = 9'd4;
          end else begin
            cp_src_nxt = AW'(22); cp_dst_nxt = AW'(22) + AW'(n_r); cp_cnt_nxt = n_r;
          end
        end
        PH_BODYCP: begin
          ph_nxt = PH_BODYWR; st_nxt = ST_WLIST; wl_mac_nxt = 1'b0; wl_j_nxt = '0;
        end
        default: st_nxt = ST_VERD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_MACCP; wc_r <= '0; ri_r <= '0; olen_r <= '0;
      verd_r <= aicr_pkg::ACT_DROP; mode_r <= aicr_pkg::MODE_NONE; gi_r <= '0;
      gv_r <= 1'b0; wv_r <= 1'b0; cp_i_r <= '0; cp_cnt_r <= '0; wl_mac_r <= 1'b0;
      wl_j_r <= '0; pend_r <= 1'b0; out_valid_r <= 1'b0;
      ip_r <= '0; mac_r <= aicr_pkg::MAC_RESET; port_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; wc_r <= wc_nxt; ri_r <= ri_nxt; olen_r <= olen_nxt;
      verd_r <= verd_nxt; mode_r <= mode_nxt; gi_r <= gi_nxt;
      gv_r <= gv_nxt; wv_r <= wv_nxt; cp_i_r <= cp_i_nxt; cp_cnt_r <= cp_cnt_nxt;
      wl_mac_r <= wl_mac_nxt; wl_j_r <= wl_j_nxt; pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      ip_r <= ip_nxt; mac_r <= mac_nxt; port_r <= port_nxt;
    end
    len_r <= len_nxt; n_r <= n_nxt; p_r <= p_nxt; hdr_r <= hdr_nxt; gidx_r <= gidx_nxt;
    cp_src_r <= cp_src_nxt; cp_dst_r <= cp_dst_nxt; wa_r <= wa_nxt;
    phit_r <= phit_nxt; plast_r <= plast_nxt;
    out_kind_r <= out_kind_nxt; out_act_r <= out_act_nxt; out_len_r <= out_len_nxt;
    out_byte_r <= out_byte_nxt; out_last_r <= out_last_nxt;
  end

  `AICR_ASSERT_NOW(a_ready_idle, in_tready, st_r == ST_IDLE && !pend_r)
  `AICR_ASSERT_NOW(a_copy_write, wv_r, st_r == ST_COPY)
  `AICR_ASSERT_NEXT(a_tick_lands, pend_r, out_valid_r && out_kind_r)
  `AICR_ASSERT_NEXT(a_dec_busy, st_r == ST_DEC, st_r != ST_IDLE)

endmodule

### design/aicr_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module aicr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/aicr_decide.sv
// Frame classification from the fetched header bytes.
// Depends on aicr_pkg.
module aicr_decide #(
  parameter int LEN_W = 12
) (
  input  aicr_pkg::hdr_t   hdr,
  input  logic [LEN_W-1:0] len,
  input  logic [31:0]      local_ip,
  input  logic [15:0]      control_port,
  output aicr_pkg::dec_t   dec
);

  logic [16:0] len17;
  logic [15:0] etype;
  logic [31:0] daddr;
  logic [3:0]  hw;
  logic [16:0] tot;
  logic [16:0] p17;

  always_comb begin
    len17 = 17'(len);
    etype = {hdr[0], hdr[1]};
    daddr = {hdr[8], hdr[9], hdr[10], hdr[11]};
    hw    = hdr[2][3:0];
    tot   = 17'({hdr[3], hdr[4]});
    dec.action = aicr_pkg::ACT_DROP;
    dec.mode   = aicr_pkg::MODE_NONE;
    dec.olen   = '0;
    dec.p      = 7'd14 + 7'({hw, 2'b00});
    dec.n      = 9'(hdr[5]) + 9'(hdr[6]);
    p17        = 17'(dec.p);
    if (len17 < 17'd14) begin
      dec.action = aicr_pkg::ACT_DROP;
    end else if (etype == 16'h0800) begin
      if (len17 < 17'd34) begin
        dec.action = aicr_pkg::ACT_DROP;
      end else if (daddr != local_ip && daddr != 32'd0) begin
        dec.action = aicr_pkg::ACT_DROP;
      end else if (hw < 4'd5) begin
        dec.action = aicr_pkg::ACT_DROP;
      end else if (hdr[7] == 8'd17) begin
        if (len17 >= p17 + 17'd4 && {hdr[13], hdr[14]} == control_port) begin
          dec.action = aicr_pkg::ACT_HOST;
          dec.olen   = len17;
        end
      end else if (hdr[7] == 8'd1 && daddr != 32'd0 && len17 >= p17 + 17'd4 &&
                   hdr[12] == 8'd8) begin
        if (tot >= 17'({hw, 2'b00}) + 17'd8 && tot + 17'd14 <= len17) begin
          dec.action = aicr_pkg::ACT_REPLY;
          dec.mode   = aicr_pkg::MODE_ICMP;
          dec.olen   = tot + 17'd14;
        end
      end
    end else if (etype == 16'h0806) begin
      if (len17 >= 17'd22 && {hdr[3], hdr[4]} == 16'h0800 &&
          17'({dec.n, 1'b0}) + 17'd22 <= len17) begin
        dec.action = aicr_pkg::ACT_REPLY;
        dec.mode   = aicr_pkg::MODE_ARP;
        dec.olen   = 17'({dec.n, 1'b0}) + 17'd22;
      end
    end
  end

endmodule
